// ----- rtl/pnsp_pkg.sv -----
package pnsp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_RD,
        ST_F1,
        ST_F2,
        ST_F3
    } state_t;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] ADDR_SEGMENTS_IN_USE = 2'd0;
    localparam logic [4:0] SEGMENTS_IN_USE_RESET = 5'd4;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] direction;
        logic [31:0] normal;
        logic [30:0] length;
    } seg_entry_t;

endpackage

// ----- rtl/polyline_nearest_segment_projector.sv -----
// a query scans segments_in_use entries (at least 1, at most MAX_SEGMENTS), rereads the nearest and projects onto it
// busy stays high from acceptance until the result strobe; no new start is accepted before the query is through
// write items leave busy low and give no result
// one query at a time; the scan issues one table read per cycle through an 8 stage pipeline
// reset: asynchronous, active low; segments_in_use returns to 4, table contents undefined
// results cannot be stalled by the receiver: each strobe lasts one cycle
module polyline_nearest_segment_projector #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [3:0]         seg_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [15:0] vec_x,
    input  logic signed [15:0] vec_y,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic [30:0]        seg_len,
    output logic               result_valid,
    output logic [3:0]         nearest_seg,
    output logic signed [31:0] along,
    output logic signed [31:0] across,
    output logic signed [15:0] head_cos,
    output logic signed [15:0] head_sin,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    pnsp_pkg::seg_entry_t mem [MAX_SEGMENTS];
    pnsp_pkg::seg_entry_t mq_reg;
    pnsp_pkg::state_t     state_reg, state_next;

    logic [4:0]         siu_reg;
    logic [CW-1:0]      cnt_reg, cnt_q;
    logic [CW-1:0]      iss_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      best_reg;
    logic [62:0]        best_d_reg;
    logic               accept, wr_en, issue_last;

    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] vx_reg, vy_reg;

    // scan pipeline
    logic [6:0]         v_reg;
    logic [6:0]         last_reg;
    logic [AW-1:0]      idx_reg [7];
    logic signed [32:0] s1_rx_reg, s1_ry_reg, s2_rx_reg, s2_ry_reg, s3_rx_reg, s3_ry_reg;
    logic signed [32:0] s4_rx_reg, s4_ry_reg;
    logic signed [15:0] s1_ex_reg, s1_ey_reg, s1_nx_reg, s1_ny_reg;
    logic signed [15:0] s2_ex_reg, s2_ey_reg, s3_ex_reg, s3_ey_reg;
    logic [30:0]        s1_len_reg, s2_len_reg;
    logic signed [48:0] s2_px_reg, s2_py_reg;
    logic [30:0]        s3_c_reg;
    logic signed [47:0] s4_cx_reg, s4_cy_reg;
    logic signed [30:0] s5_dx_reg, s5_dy_reg;
    logic signed [61:0] s6_qx_reg, s6_qy_reg;

    logic signed [49:0] s3_sum;
    logic signed [35:0] s3_t;
    logic [30:0]        s3_c;
    logic signed [34:0] s5_ex, s5_ey;
    logic [62:0]        s7_d;

    // final projection
    logic signed [48:0] f_ax_reg, f_ay_reg, f_nx_reg, f_ny_reg;
    logic signed [31:0] f_hx_reg, f_hy_reg, f_sx_reg, f_sy_reg;
    logic signed [49:0] f_along_sum, f_across_sum;
    logic signed [32:0] f_cos_sum, f_sin_sum;
    logic signed [35:0] f_along_t, f_across_t;
    logic signed [18:0] f_cos_t, f_sin_t;

    logic               done_reg;
    logic [3:0]         out_seg_reg;
    logic signed [31:0] out_along_reg, out_across_reg;
    logic signed [15:0] out_cos_reg, out_sin_reg;

    assign accept = start && !busy;
    assign wr_en  = accept && (mode == pnsp_pkg::MODE_WRITE)
                    && ({28'd0, seg_index} < 32'(MAX_SEGMENTS));
    assign issue_last = (iss_reg == cnt_reg - CW'(1));

    always_comb
    begin
        if (siu_reg == 5'd0)
            cnt_q = CW'(1);
        else if (32'(siu_reg) > 32'(MAX_SEGMENTS))
            cnt_q = CW'(MAX_SEGMENTS);
        else
            cnt_q = CW'(siu_reg);
    end

    // config port
    assign pready = 1'b1;
    always_comb
    begin
        if (paddr == pnsp_pkg::ADDR_SEGMENTS_IN_USE)
            prdata = {27'd0, siu_reg};
        else
            prdata = 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            siu_reg <= pnsp_pkg::SEGMENTS_IN_USE_RESET;
        else if (psel && penable && pwrite && pready
                 && paddr == pnsp_pkg::ADDR_SEGMENTS_IN_USE)
            siu_reg <= pwdata[4:0];
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pnsp_pkg::ST_IDLE:
            begin
                if (accept && mode == pnsp_pkg::MODE_QUERY)
                    state_next = pnsp_pkg::ST_SCAN;
            end
            pnsp_pkg::ST_SCAN:
            begin
                if (issue_last)
                    state_next = pnsp_pkg::ST_WAIT;
            end
            pnsp_pkg::ST_WAIT:
            begin
                if (v_reg[6] && last_reg[6])
                    state_next = pnsp_pkg::ST_RD;
            end
            pnsp_pkg::ST_RD: state_next = pnsp_pkg::ST_F1;
            pnsp_pkg::ST_F1: state_next = pnsp_pkg::ST_F2;
            pnsp_pkg::ST_F2: state_next = pnsp_pkg::ST_F3;
            pnsp_pkg::ST_F3: state_next = pnsp_pkg::ST_IDLE;
            default:         state_next = pnsp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != pnsp_pkg::ST_IDLE);
        if (state_reg == pnsp_pkg::ST_SCAN)
            rd_addr = iss_reg[AW-1:0];
        else
            rd_addr = best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pnsp_pkg::ST_IDLE;
            iss_reg   <= '0;
            v_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pnsp_pkg::ST_SCAN)
                iss_reg <= iss_reg + CW'(1);
            else
                iss_reg <= '0;
            v_reg    <= {v_reg[5:0], state_reg == pnsp_pkg::ST_SCAN};
            done_reg <= (state_reg == pnsp_pkg::ST_F3);
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(seg_index)] <= '{start_x:   point_x,
                                     start_y:   point_y,
                                     direction: {vec_y, vec_x},
                                     normal:    {normal_y, normal_x},
                                     length:    seg_len};
        mq_reg <= mem[rd_addr];
    end

    // query capture
    always_ff @(posedge clk)
    begin
        if (accept && mode == pnsp_pkg::MODE_QUERY)
        begin
            px_reg  <= point_x;
            py_reg  <= point_y;
            vx_reg  <= vec_x;
            vy_reg  <= vec_y;
            cnt_reg <= cnt_q;
        end
    end

    // scan datapath
    always_comb
    begin
        s3_sum = 50'(s2_px_reg) + 50'(s2_py_reg);
        s3_t   = s3_sum[49:14];
        if (s3_t <= 36'sd0)
            s3_c = '0;
        else if (s3_t >= $signed({5'd0, s2_len_reg}))
            s3_c = s2_len_reg;
        else
            s3_c = s3_t[30:0];
        s5_ex = 35'(s4_rx_reg) - 35'($signed(s4_cx_reg[47:14]));
        s5_ey = 35'(s4_ry_reg) - 35'($signed(s4_cy_reg[47:14]));
        s7_d  = {1'b0, s6_qx_reg} + {1'b0, s6_qy_reg};
    end

    always_ff @(posedge clk)
    begin
        idx_reg[0]  <= iss_reg[AW-1:0];
        last_reg[0] <= issue_last;
        for (int k = 1; k < 7; k++)
        begin
            idx_reg[k]  <= idx_reg[k-1];
            last_reg[k] <= last_reg[k-1];
        end
        s1_rx_reg  <= $signed({px_reg[31], px_reg}) - $signed({mq_reg.start_x[31], mq_reg.start_x});
        s1_ry_reg  <= $signed({py_reg[31], py_reg}) - $signed({mq_reg.start_y[31], mq_reg.start_y});
        s1_ex_reg  <= $signed(mq_reg.direction[15:0]);
        s1_ey_reg  <= $signed(mq_reg.direction[31:16]);
        s1_nx_reg  <= $signed(mq_reg.normal[15:0]);
        s1_ny_reg  <= $signed(mq_reg.normal[31:16]);
        s1_len_reg <= mq_reg.length;

        s2_px_reg  <= s1_rx_reg * s1_ex_reg;
        s2_py_reg  <= s1_ry_reg * s1_ey_reg;
        s2_rx_reg  <= s1_rx_reg;
        s2_ry_reg  <= s1_ry_reg;
        s2_ex_reg  <= s1_ex_reg;
        s2_ey_reg  <= s1_ey_reg;
        s2_len_reg <= s1_len_reg;

        s3_c_reg   <= s3_c;
        s3_rx_reg  <= s2_rx_reg;
        s3_ry_reg  <= s2_ry_reg;
        s3_ex_reg  <= s2_ex_reg;
        s3_ey_reg  <= s2_ey_reg;

        s4_cx_reg  <= $signed({1'b0, s3_c_reg}) * s3_ex_reg;
        s4_cy_reg  <= $signed({1'b0, s3_c_reg}) * s3_ey_reg;
        s4_rx_reg  <= s3_rx_reg;
        s4_ry_reg  <= s3_ry_reg;

        s5_dx_reg  <= s5_ex[34:4];
        s5_dy_reg  <= s5_ey[34:4];

        s6_qx_reg  <= s5_dx_reg * s5_dx_reg;
        s6_qy_reg  <= s5_dy_reg * s5_dy_reg;

        if (v_reg[6] && (idx_reg[6] == '0 || s7_d < best_d_reg))
        begin
            best_d_reg <= s7_d;
            best_reg   <= idx_reg[6];
        end
    end

    // final projection
    always_comb
    begin
        f_along_sum  = 50'(f_ax_reg) + 50'(f_ay_reg);
        f_across_sum = 50'(f_nx_reg) + 50'(f_ny_reg);
        f_cos_sum    = 33'(f_hx_reg) + 33'(f_hy_reg);
        f_sin_sum    = 33'(f_sx_reg) + 33'(f_sy_reg);
        f_along_t    = f_along_sum[49:14];
        f_across_t   = f_across_sum[49:14];
        f_cos_t      = f_cos_sum[32:14];
        f_sin_t      = f_sin_sum[32:14];
    end

    always_ff @(posedge clk)
    begin
        f_ax_reg <= s1_rx_reg * s1_ex_reg;
        f_ay_reg <= s1_ry_reg * s1_ey_reg;
        f_nx_reg <= s1_rx_reg * s1_nx_reg;
        f_ny_reg <= s1_ry_reg * s1_ny_reg;
        f_hx_reg <= vx_reg * s1_ex_reg;
        f_hy_reg <= vy_reg * s1_ey_reg;
        f_sx_reg <= vx_reg * s1_nx_reg;
        f_sy_reg <= vy_reg * s1_ny_reg;
        if (state_reg == pnsp_pkg::ST_F3)
        begin
            out_seg_reg <= 4'(best_reg);
            if (f_along_t > 36'sh07FFFFFFF)
                out_along_reg <= 32'sh7FFFFFFF;
            else if (f_along_t < -36'sh080000000)
                out_along_reg <= 32'sh80000000;
            else
                out_along_reg <= f_along_t[31:0];
            if (f_across_t > 36'sh07FFFFFFF)
                out_across_reg <= 32'sh7FFFFFFF;
            else if (f_across_t < -36'sh080000000)
                out_across_reg <= 32'sh80000000;
            else
                out_across_reg <= f_across_t[31:0];
            if (f_cos_t > 19'sd16384)
                out_cos_reg <= 16'sd16384;
            else if (f_cos_t < -19'sd16384)
                out_cos_reg <= -16'sd16384;
            else
                out_cos_reg <= f_cos_t[15:0];
            if (f_sin_t > 19'sd16384)
                out_sin_reg <= 16'sd16384;
            else if (f_sin_t < -19'sd16384)
                out_sin_reg <= -16'sd16384;
            else
                out_sin_reg <= f_sin_t[15:0];
        end
    end

    assign result_valid = done_reg;
    assign nearest_seg  = out_seg_reg;
    assign along        = out_along_reg;
    assign across       = out_across_reg;
    assign head_cos     = out_cos_reg;
    assign head_sin     = out_sin_reg;

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == pnsp_pkg::MODE_QUERY |=> busy)
        else $error("query transfer did not start a search");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == pnsp_pkg::MODE_WRITE |=> !busy && !result_valid)
        else $error("write transfer caused activity");

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == pnsp_pkg::ST_F3))
        else $error("result strobe outside final stage");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pnsp_pkg::ST_RD |-> $past(v_reg[6] && last_reg[6]))
        else $error("final read before scan completed");

endmodule
